@@ src/gri_pkg.sv @@
// ----------------------------------------------------------------------------
// gri_pkg - shared types and constants for the gyro angle integrator
// Sample window geometry, register indexes, reset values, ASCII codes and the
// structs passed between the sequencer, the multiply unit and the reporter.
// ----------------------------------------------------------------------------
package gri_pkg;

  // Window geometry
  localparam int WINDOW      = 25;
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_W       = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int CNT_W       = $clog2(WINDOW + 1);

  // Field widths
  localparam int TICKS_W  = 8;
  localparam int CHAR_W   = 8;
  localparam int TENTHS_W = 11;
  localparam int MAG_W    = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 3'd4;

  localparam logic [15:0] RST_RATE_GAIN   = 16'd19123;
  localparam logic [23:0] RST_TICK_LENGTH = 24'd549756;
  localparam logic [9:0]  RST_DEADBAND    = 10'd12;
  localparam logic [6:0]  RST_SNAP_LIMIT  = 7'd5;
  localparam logic [6:0]  RST_ANGLE_LIMIT = 7'd90;

  // Shared multiply unit: 33 x 8 with byte-shifted accumulate
  localparam int MAC_A_W = 33;
  localparam int MAC_B_W = 8;
  localparam int ACC_W   = MAC_A_W + 32;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;

  localparam logic [MAG_W-1:0] TENTHS_MAX = 10'd999;

  typedef struct packed {
    logic [15:0] rate_gain;
    logic [23:0] tick_length;
    logic [9:0]  deadband_counts;
    logic [6:0]  snap_limit;
    logic [6:0]  angle_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
  } mac_op_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } rpt_req_t;

endpackage

@@ src/gri_if.sv @@
// ----------------------------------------------------------------------------
// gri_if - channel interfaces of the gyro angle integrator
// Sample input, character report output and register write channels.
// ----------------------------------------------------------------------------
interface gri_in_if import gri_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TICKS_W-1:0]     elapsed_ticks;

  modport source (output valid, sample, elapsed_ticks, input ready);
  modport sink (input valid, sample, elapsed_ticks, output ready);
endinterface

interface gri_out_if import gri_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHAR_W-1:0]          out_char;
  logic                       last;
  logic signed [TENTHS_W-1:0] angle_tenths;

  modport source (output valid, out_char, last, angle_tenths, input ready);
  modport sink (input valid, out_char, last, angle_tenths, output ready);
endinterface

interface gri_cfg_if import gri_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/gri_mac.sv @@
// ----------------------------------------------------------------------------
// gri_mac - shared multiply-accumulate unit
// One 33 x 8 product per cycle; the accumulator either loads the product or
// shifts left a byte and adds it, so wide products are built MSB byte first.
// ----------------------------------------------------------------------------
module gri_mac import gri_pkg::*; (
  input  logic             clk,
  input  mac_op_t          op,
  output logic [ACC_W-1:0] acc
);

  logic [MAC_A_W+MAC_B_W-1:0] prod;

  // partial product
  assign prod = op.a * op.b;

  // accumulator holds while idle
  always_ff @(posedge clk) begin
    if (op.en) begin
      if (op.clr) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= (acc << MAC_B_W) + ACC_W'(prod);
      end
    end
  end

endmodule

@@ src/gri_seq.sv @@
// ----------------------------------------------------------------------------
// gri_seq - window accumulation and angle integration sequencer
// Sums sample windows, derives the rate, integrates the angle with the
// shared multiply unit and hands the tenths magnitude to the reporter.
// ----------------------------------------------------------------------------
module gri_seq import gri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg_regs,
  gri_in_if.sink    samples,
  output rpt_req_t  req,
  input  logic      rpt_busy
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_RATE_HI  = 12'b0000_0000_0010,
    S_RATE_LO  = 12'b0000_0000_0100,
    S_RATE_FIN = 12'b0000_0000_1000,
    S_DT       = 12'b0000_0001_0000,
    S_INC3     = 12'b0000_0010_0000,
    S_INC2     = 12'b0000_0100_0000,
    S_INC1     = 12'b0000_1000_0000,
    S_INC0     = 12'b0001_0000_0000,
    S_MOVE     = 12'b0010_0000_0000,
    S_TENTHS   = 12'b0100_0000_0000,
    S_HANDOFF  = 12'b1000_0000_0000
  } seq_state_t;

  localparam logic [MAC_B_W-1:0] TEN = 8'd10;
  localparam logic [ACC_W-1:0] POS_MAX_MAG = ACC_W'(64'h7FFF_FFFF);
  localparam logic [ACC_W-1:0] NEG_MAX_MAG = ACC_W'(64'h8000_0000);

  seq_state_t state;

  // architectural state
  logic [CNT_W-1:0]    sample_count;
  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    bias_sum;
  logic                bias_ready;
  logic signed [31:0]  prev_rate;
  logic signed [31:0]  angle;

  // working registers
  logic signed [SUM_W:0] diff;
  logic [TICKS_W-1:0]    ticks;
  logic                  rest;
  logic signed [31:0]    rate;
  logic [MAC_A_W-1:0]    sum_mag;
  logic                  sum_neg;
  logic [31:0]           dt;

  logic [ACC_W-1:0] acc;
  mac_op_t          op;

  logic                  accept;
  logic [SUM_W-1:0]      sum_new;
  logic                  window_done;
  logic [SUM_W-1:0]      diff_mag;
  logic                  rate_ovf;
  logic signed [31:0]    rate_val;
  logic signed [31:0]    snap_lim;
  logic signed [32:0]    rate_sum;
  logic [39:0]           inc;
  logic signed [41:0]    ang_wide;
  logic signed [41:0]    ang_step;
  logic signed [41:0]    lim_wide;
  logic signed [31:0]    ang_clamped;
  logic [MAC_A_W-1:0]    ang_mag;
  logic [ACC_W-25:0]     tenths_raw;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign sum_new       = window_sum + SUM_W'(samples.sample);
  assign window_done   = (sample_count == CNT_W'(WINDOW - 1));

  // magnitude of the window difference
  assign diff_mag = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];

  // signed rate, saturated to 32 bits
  assign rate_ovf = diff[SUM_W] ? (acc > NEG_MAX_MAG) : (acc > POS_MAX_MAG);
  always_comb begin
    if (rate_ovf) begin
      rate_val = diff[SUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rate_val = diff[SUM_W] ? -$signed(acc[31:0]) : $signed(acc[31:0]);
    end
  end

  assign snap_lim = $signed({1'b0, cfg_regs.snap_limit, 24'b0});
  assign rate_sum = 33'(prev_rate) + 33'(rate);

  // trapezoid step and saturation
  assign inc      = acc[ACC_W-1:25];
  assign ang_wide = 42'(angle);
  assign ang_step = sum_neg ? ang_wide - $signed({2'b0, inc}) : ang_wide + $signed({2'b0, inc});
  assign lim_wide = $signed(42'({cfg_regs.angle_limit, 24'b0}));
  always_comb begin
    if (ang_step > lim_wide) begin
      ang_clamped = 32'(lim_wide);
    end else if (ang_step < -lim_wide) begin
      ang_clamped = 32'(-lim_wide);
    end else begin
      ang_clamped = 32'(ang_step);
    end
  end

  assign ang_mag    = angle[31] ? MAC_A_W'(-33'(angle)) : MAC_A_W'(angle);
  assign tenths_raw = acc[ACC_W-1:24];

  // multiply unit schedule
  always_comb begin
    op = '0;
    case (state)
      S_RATE_HI: begin
        op = '{en: 1'b1, clr: 1'b1, a: MAC_A_W'(diff_mag), b: cfg_regs.rate_gain[15:8]};
      end
      S_RATE_LO: begin
        op = '{en: 1'b1, clr: 1'b0, a: MAC_A_W'(diff_mag), b: cfg_regs.rate_gain[7:0]};
      end
      S_DT: begin
        op = '{en: 1'b1, clr: 1'b1, a: MAC_A_W'(cfg_regs.tick_length), b: ticks};
      end
      S_INC3: begin
        op = '{en: 1'b1, clr: 1'b1, a: sum_mag, b: acc[31:24]};
      end
      S_INC2: begin
        op = '{en: 1'b1, clr: 1'b0, a: sum_mag, b: dt[23:16]};
      end
      S_INC1: begin
        op = '{en: 1'b1, clr: 1'b0, a: sum_mag, b: dt[15:8]};
      end
      S_INC0: begin
        op = '{en: 1'b1, clr: 1'b0, a: sum_mag, b: dt[7:0]};
      end
      S_TENTHS: begin
        op = '{en: 1'b1, clr: 1'b1, a: ang_mag, b: TEN};
      end
      default: begin
        op = '0;
      end
    endcase
  end

  gri_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // report request, held until the reporter is free
  always_comb begin
    req.valid = (state == S_HANDOFF);
    req.neg   = angle[31];
    req.mag   = (tenths_raw > (ACC_W-24)'(TENTHS_MAX)) ? TENTHS_MAX : tenths_raw[MAG_W-1:0];
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      window_sum   <= '0;
      bias_sum     <= '0;
      bias_ready   <= 1'b0;
      prev_rate    <= '0;
      angle        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (window_done) begin
              window_sum   <= '0;
              sample_count <= '0;
              if (!bias_ready) begin
                bias_sum   <= sum_new;
                bias_ready <= 1'b1;
              end else begin
                state <= S_RATE_HI;
              end
            end else begin
              window_sum   <= sum_new;
              sample_count <= sample_count + 1'b1;
            end
          end
        end
        S_RATE_HI: begin
          state <= S_RATE_LO;
        end
        S_RATE_LO: begin
          state <= S_RATE_FIN;
        end
        S_RATE_FIN: begin
          if (rest) begin
            prev_rate <= '0;
            if (angle >= -snap_lim && angle <= snap_lim) begin
              angle <= '0;
            end
          end
          state <= S_DT;
        end
        S_DT: begin
          state <= S_INC3;
        end
        S_INC3: begin
          state <= S_INC2;
        end
        S_INC2: begin
          state <= S_INC1;
        end
        S_INC1: begin
          state <= S_INC0;
        end
        S_INC0: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          angle     <= ang_clamped;
          prev_rate <= rate;
          state     <= S_TENTHS;
        end
        S_TENTHS: begin
          state <= S_HANDOFF;
        end
        S_HANDOFF: begin
          if (!rpt_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      diff  <= $signed({1'b0, sum_new}) - $signed({1'b0, bias_sum});
      ticks <= samples.elapsed_ticks;
    end
    if (state == S_RATE_HI) begin
      rest <= (MAC_A_W'(diff_mag) <= MAC_A_W'(cfg_regs.deadband_counts));
    end
    if (state == S_RATE_FIN) begin
      rate <= rest ? 32'sd0 : rate_val;
    end
    if (state == S_DT) begin
      sum_neg <= rate_sum[32];
      sum_mag <= rate_sum[32] ? MAC_A_W'(-rate_sum) : MAC_A_W'(rate_sum);
    end
    if (state == S_INC3) begin
      dt <= acc[31:0];
    end
  end

endmodule

@@ src/gri_report.sv @@
// ----------------------------------------------------------------------------
// gri_report - ASCII angle reporter
// Splits the tenths magnitude into decimal digits by repeated subtraction and
// sends sign, three digits and newline, one character per transaction.
// ----------------------------------------------------------------------------
module gri_report import gri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rpt_req_t  req,
  output logic      busy,
  gri_out_if.source report
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_HUND = 4'b0010,
    R_TENS = 4'b0100,
    R_EMIT = 4'b1000
  } rpt_state_t;

  localparam logic [2:0] POS_SIGN = 3'd0;
  localparam logic [2:0] POS_HUND = 3'd1;
  localparam logic [2:0] POS_TENS = 3'd2;
  localparam logic [2:0] POS_ONES = 3'd3;
  localparam logic [2:0] POS_NL   = 3'd4;

  localparam logic [MAG_W-1:0] HUNDRED = 10'd100;
  localparam logic [MAG_W-1:0] TEN     = 10'd10;

  rpt_state_t                 state;
  logic [MAG_W-1:0]           rem;
  logic [3:0]                 dig_h;
  logic [3:0]                 dig_t;
  logic [2:0]                 pos;
  logic                       neg;
  logic signed [TENTHS_W-1:0] tenths;

  assign busy                = (state != R_IDLE);
  assign report.valid        = (state == R_EMIT);
  assign report.last         = (pos == POS_NL);
  assign report.angle_tenths = tenths;

  // character select
  always_comb begin
    case (pos)
      POS_SIGN: report.out_char = neg ? CHAR_MINUS : CHAR_PLUS;
      POS_HUND: report.out_char = CHAR_ZERO + CHAR_W'(dig_h);
      POS_TENS: report.out_char = CHAR_ZERO + CHAR_W'(dig_t);
      POS_ONES: report.out_char = CHAR_ZERO + CHAR_W'(rem[3:0]);
      default:  report.out_char = CHAR_NL;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      pos   <= POS_SIGN;
    end else begin
      case (state)
        R_IDLE: begin
          if (req.valid) begin
            pos   <= POS_SIGN;
            state <= R_HUND;
          end
        end
        R_HUND: begin
          if (rem < HUNDRED) begin
            state <= R_TENS;
          end
        end
        R_TENS: begin
          if (rem < TEN) begin
            state <= R_EMIT;
          end
        end
        R_EMIT: begin
          if (report.ready) begin
            if (pos == POS_NL) begin
              state <= R_IDLE;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  // digit extraction
  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (req.valid) begin
          rem    <= req.mag;
          dig_h  <= '0;
          dig_t  <= '0;
          neg    <= req.neg;
          tenths <= req.neg ? -$signed(TENTHS_W'(req.mag)) : $signed(TENTHS_W'(req.mag));
        end
      end
      R_HUND: begin
        if (rem >= HUNDRED) begin
          rem   <= rem - HUNDRED;
          dig_h <= dig_h + 1'b1;
        end
      end
      R_TENS: begin
        if (rem >= TEN) begin
          rem   <= rem - TEN;
          dig_t <= dig_t + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/gyro_rate_angle_integrator_unit.sv @@
// ----------------------------------------------------------------------------
// gyro_rate_angle_integrator_unit - gyro rate to angle integrator
// Integrates windowed gyro samples into an angle and reports it in ASCII.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one gyro reading and the window's timer ticks per transaction.
//   report  : five character transactions per window after the bias window:
//             sign, hundreds, tens and ones of tenths of a degree, newline
//             (last set); angle_tenths is the same on all five.
//   cfg     : register writes, always ready; write only while idle.
// Sequencing: the input stays ready after a sample that does not close a window.
//   A window's closing sample keeps the input busy through 11 sequencer steps,
//   eight of them on the shared 33 x 8 multiply unit (two for the rate, tick
//   product, four byte steps of the angle increment, tenths scaling). The
//   first character then waits for the reporter's digit subtraction loop.
// Reset: the first 25 samples after reset form the bias and give no report;
//   registers return to their defaults, angle and rate to zero.
// Stall: a stalled report holds its character; a following window waits in
//   the sequencer and the input stays not ready until the reporter is free.
// ----------------------------------------------------------------------------
module gyro_rate_angle_integrator_unit import gri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gri_in_if.sink    samples,
  gri_out_if.source report,
  gri_cfg_if.sink   cfg
);

  cfg_regs_t cfg_regs;
  rpt_req_t  req;
  logic      rpt_busy;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.rate_gain       <= RST_RATE_GAIN;
      cfg_regs.tick_length     <= RST_TICK_LENGTH;
      cfg_regs.deadband_counts <= RST_DEADBAND;
      cfg_regs.snap_limit      <= RST_SNAP_LIMIT;
      cfg_regs.angle_limit     <= RST_ANGLE_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RATE_GAIN:   cfg_regs.rate_gain       <= cfg.data[15:0];
        REG_TICK_LENGTH: cfg_regs.tick_length     <= cfg.data[23:0];
        REG_DEADBAND:    cfg_regs.deadband_counts <= cfg.data[9:0];
        REG_SNAP_LIMIT:  cfg_regs.snap_limit      <= cfg.data[6:0];
        REG_ANGLE_LIMIT: cfg_regs.angle_limit     <= cfg.data[6:0];
        default: begin
        end
      endcase
    end
  end

  gri_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .samples  (samples),
    .req      (req),
    .rpt_busy (rpt_busy)
  );

  gri_report u_report (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .busy   (rpt_busy),
    .report (report)
  );

`ifndef SYNTHESIS
  // nothing is reported straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !report.valid)
    else $error("report valid right after reset");

  // a newline ends the report; the next one needs digit work first
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.ready && report.last |=> !report.valid)
    else $error("report continued after its newline");

  // reported tenths stay within three digits
  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    report.valid |-> (report.angle_tenths <= 11'sd999 && report.angle_tenths >= -11'sd999))
    else $error("angle tenths out of range");
`endif

endmodule
